>>> hdl/lpmd_pkg.sv
// package for the length-prefixed message deframer
// holds the parser phase type and the result item struct; no dependencies

package lpmd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned WORD_W = 16;

   // which byte of the stream is expected next
   typedef enum logic [4:0] {
      PH_ID_HI  = 5'b00001,
      PH_ID_LO  = 5'b00010,
      PH_LEN_HI = 5'b00100,
      PH_LEN_LO = 5'b01000,
      PH_BODY   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [WORD_W-1:0] message_id;
      logic [WORD_W-1:0] message_len;
      logic [BYTE_W-1:0] body_byte;
      logic              body_valid;
      logic              last_of_message;
   } result_type;

endpackage

>>> hdl/lpmd_parser.sv
// header parser and body counter of the deframer
// updates the framing state on each accepted byte; uses lpmd_pkg

module lpmd_parser
   import lpmd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [BYTE_W-1:0] data_byte,
   output logic              has_result,
   output result_type        result
);

   phase_type         phase_ff, phase_in;
   logic [WORD_W-1:0] id_ff, id_in;
   logic [WORD_W-1:0] len_ff, len_in;
   logic [WORD_W-1:0] left_ff, left_in;

   always_comb begin
      phase_in   = phase_ff;
      id_in      = id_ff;
      len_in     = len_ff;
      left_in    = left_ff;
      has_result = 1'b0;
      result     = '0;
      case (phase_ff)
         PH_ID_LO: begin
            id_in    = {id_ff[WORD_W-1:BYTE_W], data_byte};
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len_in   = {data_byte, {BYTE_W{1'b0}}};
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_in = {len_ff[WORD_W-1:BYTE_W], data_byte};
            if (len_in == '0) begin
               // empty message: one item with no body byte
               left_in                = '0;
               phase_in               = PH_ID_HI;
               has_result             = 1'b1;
               result.message_id      = id_ff;
               result.message_len     = len_in;
               result.last_of_message = 1'b1;
            end else begin
               left_in  = len_in;
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            // count saturates at zero
            if (left_ff != '0) begin
               left_in = left_ff - WORD_W'(1);
            end
            if (left_in == '0) begin
               phase_in = PH_ID_HI;
            end
            has_result             = 1'b1;
            result.message_id      = id_ff;
            result.message_len     = len_ff;
            result.body_byte       = data_byte;
            result.body_valid      = 1'b1;
            result.last_of_message = (left_in == '0);
         end
         default: begin
            id_in    = {data_byte, {BYTE_W{1'b0}}};
            phase_in = PH_ID_LO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ID_HI;
         id_ff    <= '0;
         len_ff   <= '0;
         left_ff  <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
      end
   end

   a_body_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> left_ff != '0)
      else $error("body phase with no bytes left");

   a_left_within_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> left_ff <= len_ff)
      else $error("bytes left exceeds message length");

   a_last_leaves_body: assert property (@(posedge clock) disable iff (reset)
      take && has_result && result.last_of_message |=> phase_ff == PH_ID_HI)
      else $error("last item did not return to header phase");

endmodule

>>> hdl/lpmd_out_buf.sv
// result register with a skid entry
// parts the result channel's ready from the input side; uses lpmd_pkg

module lpmd_out_buf
   import lpmd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       can_load,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       out_valid_ff;
   logic       skid_valid_ff;
   result_type out_ff;
   result_type skid_ff;
   logic       pop;

   assign pop       = out_valid_ff && out_ready;
   assign can_load  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (load && out_valid_ff && !pop) begin
         skid_valid_ff <= 1'b1;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (load && out_valid_ff && !pop) begin
         skid_ff <= load_data;
      end else if (load) begin
         out_ff <= load_data;
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while result register empty");

   a_no_load_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !load)
      else $error("item loaded while both entries full");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> out_valid_ff && out_ff == $past(skid_ff))
      else $error("skid entry not moved into result register");

endmodule

>>> hdl/length_prefixed_message_deframer_top.sv
// top level of the length-prefixed message deframer
// joins lpmd_parser and lpmd_out_buf; uses lpmd_pkg
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data_byte
//   rsp      out        rsp_valid / rsp_ready  rsp_message_id, rsp_message_len,
//                                              rsp_body_byte, rsp_body_valid,
//                                              rsp_last_of_message
//
// one byte accepted per cycle while req_ready is high; results are registered
// header bytes give no result; each body byte, or an empty message, gives one
// synchronous active-high reset returns the parser to the identifier high byte
// a two-entry output buffer keeps req_ready independent of rsp_ready;
// req_ready drops only while both entries hold results

module length_prefixed_message_deframer_top
   import lpmd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_message_id,
   output logic [WORD_W-1:0] rsp_message_len,
   output logic [BYTE_W-1:0] rsp_body_byte,
   output logic              rsp_body_valid,
   output logic              rsp_last_of_message
);

   logic       take;
   logic       has_result;
   logic       can_load;
   result_type result;
   result_type out_data;

   assign req_ready = can_load;
   assign take      = req_valid && can_load;

   lpmd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .data_byte  (req_data_byte),
      .has_result (has_result),
      .result     (result)
   );

   lpmd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (take && has_result),
      .load_data (result),
      .can_load  (can_load),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_message_id      = out_data.message_id;
   assign rsp_message_len     = out_data.message_len;
   assign rsp_body_byte       = out_data.body_byte;
   assign rsp_body_valid      = out_data.body_valid;
   assign rsp_last_of_message = out_data.last_of_message;

endmodule
